>>> sv/pnc_pkg.sv
// ============================================================================
// pnc_pkg
// Shared types and constants for the path name classifier.
// ============================================================================
package pnc_pkg;

    // Width of one name byte and of the reported depth field
    localparam int CH_W    = 8;
    localparam int DEPTH_W = 8;

    // Default depth ceiling
    localparam int MAX_DEPTH_DEF = 255;

    // Byte handed from the input register to the classifier core
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] ch;
    } pnc_byte_t;

    // One classification result
    typedef struct packed {
        logic               invalid;
        logic               has_drive;
        logic               has_path;
        logic               absolute;
        logic               ends_slash;
        logic               hp_drive;
        logic               name_empty;
        logic               single_dot;
        logic               double_dot;
        logic [DEPTH_W-1:0] depth;
    } pnc_res_t;

endpackage

>>> sv/path_name_classifier.sv
// ============================================================================
// path_name_classifier
// Streams a path name byte by byte and reports its classification.
// ============================================================================
// One name byte is taken per cycle, back to back, with no gaps needed
// between names. A byte is held in the input register, then updates
// the classification state; the result of a name is presented in the cycle
// after its zero terminator transfers. Only a terminator can be held back:
// it waits in the input register while the result register is full and
// stalled, and the byte channel stalls with it. No start-up pass is needed
// after reset. Depth counts non-root separators and stops at MAX_DEPTH; the
// depth port shows its low eight bits.
module path_name_classifier #(
    parameter int MAX_DEPTH = pnc_pkg::MAX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [pnc_pkg::CH_W-1:0]    ch,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        invalid,
    output logic                        has_drive,
    output logic                        has_path,
    output logic                        absolute,
    output logic                        ends_slash,
    output logic                        hp_drive,
    output logic                        name_empty,
    output logic                        single_dot,
    output logic                        double_dot,
    output logic [pnc_pkg::DEPTH_W-1:0] depth
);
    import pnc_pkg::*;

    pnc_byte_t step;
    logic      res_room;
    logic      core_valid;
    pnc_res_t  core_res;
    pnc_res_t  res_q;

    pnc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .ch         (ch),
        .res_room   (res_room),
        .step       (step)
    );

    pnc_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (core_valid),
        .res       (core_res)
    );

    pnc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (core_valid),
        .res_in    (core_res),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .room      (res_room),
        .res_out   (res_q)
    );

    // Result fields
    assign invalid    = res_q.invalid;
    assign has_drive  = res_q.has_drive;
    assign has_path   = res_q.has_path;
    assign absolute   = res_q.absolute;
    assign ends_slash = res_q.ends_slash;
    assign hp_drive   = res_q.hp_drive;
    assign name_empty = res_q.name_empty;
    assign single_dot = res_q.single_dot;
    assign double_dot = res_q.double_dot;
    assign depth      = res_q.depth;

endmodule

>>> sv/pnc_in_stage.sv
// ============================================================================
// pnc_in_stage
// Input register for name bytes. A non-terminator byte always moves on in
// the next cycle; a terminator waits here until the result register has room.
// ============================================================================
module pnc_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  logic [pnc_pkg::CH_W-1:0] ch,
    input  logic                   res_room,
    output pnc_pkg::pnc_byte_t     step
);
    import pnc_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CH_W-1:0] ch_reg;
    logic            go;
    logic            accept;

    // Held byte leaves when it is not a terminator or the result can be stored
    assign go         = valid_reg && ((ch_reg != '0) || res_room);
    assign byte_stall = valid_reg && !go;
    assign accept     = byte_valid && !byte_stall;
    assign valid_next = accept || (valid_reg && !go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= ch;
        end
    end

    assign step.valid = go;
    assign step.ch    = ch_reg;

endmodule

>>> sv/pnc_core.sv
// ============================================================================
// pnc_core
// Per-name classification state. Each byte updates flags, the byte position,
// the directory depth and the kind of the last component; the terminator
// produces the result and returns the state to its initial values.
// ============================================================================
module pnc_core #(
    parameter int MAX_DEPTH = pnc_pkg::MAX_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pnc_pkg::pnc_byte_t step,
    output logic               res_valid,
    output pnc_pkg::pnc_res_t  res
);
    import pnc_pkg::*;

    localparam int DIR_W = $clog2(MAX_DEPTH + 1);

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_BAR    = 8'h7C;

    // Byte position saturates here
    localparam logic [2:0] POS_SAT = 3'd4;

    typedef enum logic [3:0] {
        DRV_NONE      = 4'b0001,
        DRV_HP_OPEN   = 4'b0010,
        DRV_DOS       = 4'b0100,
        DRV_HP_CLOSED = 4'b1000
    } drive_t;

    typedef enum logic [4:0] {
        K_EMPTY = 5'b00001,
        K_ONE   = 5'b00010,
        K_TWO   = 5'b00100,
        K_DOTS  = 5'b01000,
        K_OTHER = 5'b10000
    } kind_t;

    logic             bad_reg,      bad_next;
    drive_t           mode_reg,     mode_next;
    logic             drive_reg,    drive_next;
    logic             path_reg,     path_next;
    logic             abs_reg,      abs_next;
    logic             hp_reg,       hp_next;
    logic [2:0]       pos_reg,      pos_next;
    logic             after_reg,    after_next;
    logic             slash_reg,    slash_next;
    logic [DIR_W-1:0] dir_reg,      dir_next;
    kind_t            kind_reg,     kind_next;

    logic c_illegal;
    logic c_dot;
    logic c_dsp;
    logic c_slash;
    logic at_drive_end;
    logic bad_final;

    // Byte decode
    assign c_illegal = (step.ch[7:5] == 3'b000) || (step.ch == CH_QUOTE) ||
                       (step.ch == CH_STAR) || (step.ch == CH_LT) ||
                       (step.ch == CH_GT) || (step.ch == CH_QMARK) ||
                       (step.ch == CH_BAR);
    assign c_dot     = (step.ch == CH_DOT);
    assign c_dsp     = c_dot || (step.ch == CH_SPACE);
    assign c_slash   = (step.ch == CH_SLASH) || (step.ch == CH_BSLASH);

    // Slash right where the drive part ends makes the path rooted
    assign at_drive_end = ((mode_reg == DRV_NONE)      && (pos_reg == 3'd0)) ||
                          ((mode_reg == DRV_DOS)       && (pos_reg == 3'd2)) ||
                          ((mode_reg == DRV_HP_CLOSED) && (pos_reg == 3'd3));

    // A trailing ".." followed by one or more dots or spaces is rejected
    assign bad_final = bad_reg || (kind_reg == K_DOTS);

    // Next state and result
    always_comb
    begin
        bad_next   = bad_reg;
        mode_next  = mode_reg;
        drive_next = drive_reg;
        path_next  = path_reg;
        abs_next   = abs_reg;
        hp_next    = hp_reg;
        pos_next   = pos_reg;
        after_next = after_reg;
        slash_next = slash_reg;
        dir_next   = dir_reg;
        kind_next  = kind_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (step.valid)
        begin
            if (step.ch != CH_NUL)
            begin
                if (!bad_reg)
                begin
                    if (c_illegal)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (step.ch == CH_COLON)
                    begin
                        // Colon: HP drive open, DOS drive, or HP drive close
                        if (pos_reg == 3'd0)
                        begin
                            mode_next = DRV_HP_OPEN;
                        end
                        else if (pos_reg == 3'd1)
                        begin
                            if (mode_reg == DRV_HP_OPEN)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mode_next  = DRV_DOS;
                                drive_next = 1'b1;
                            end
                        end
                        else if (pos_reg == 3'd2)
                        begin
                            if (mode_reg != DRV_HP_OPEN)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mode_next  = DRV_HP_CLOSED;
                                drive_next = 1'b1;
                                hp_next    = 1'b1;
                            end
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                        after_next = 1'b1;
                        slash_next = 1'b0;
                        kind_next  = K_EMPTY;
                    end
                    else if (c_slash)
                    begin
                        // Separator: root mark or one more directory level
                        if (mode_reg == DRV_HP_OPEN)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            path_next = 1'b1;
                            if (at_drive_end)
                            begin
                                abs_next = 1'b1;
                            end
                            else if (after_reg)
                            begin
                                bad_next = 1'b1;
                            end
                            else if (dir_reg < DIR_W'(MAX_DEPTH))
                            begin
                                dir_next = dir_reg + 1'b1;
                            end
                        end
                        after_next = 1'b1;
                        slash_next = 1'b1;
                        kind_next  = K_EMPTY;
                    end
                    else
                    begin
                        after_next = 1'b0;
                        slash_next = 1'b0;
                        unique case (kind_reg)
                            K_EMPTY: kind_next = c_dot ? K_ONE : K_OTHER;
                            K_ONE:   kind_next = c_dot ? K_TWO : K_OTHER;
                            K_TWO:   kind_next = c_dsp ? K_DOTS : K_OTHER;
                            K_DOTS:  kind_next = c_dsp ? K_DOTS : K_OTHER;
                            K_OTHER: kind_next = K_OTHER;
                            default: kind_next = K_OTHER;
                        endcase
                    end
                end
                if (pos_reg < POS_SAT)
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            else
            begin
                // Terminator: report and start over
                res_valid   = 1'b1;
                res.invalid = bad_final;
                if (!bad_final)
                begin
                    res.has_drive  = drive_reg;
                    res.has_path   = path_reg;
                    res.absolute   = abs_reg;
                    res.ends_slash = slash_reg;
                    res.hp_drive   = hp_reg;
                    res.name_empty = (kind_reg == K_EMPTY);
                    res.single_dot = (kind_reg == K_ONE);
                    res.double_dot = (kind_reg == K_TWO);
                    res.depth      = DEPTH_W'(dir_reg);
                end
                bad_next   = 1'b0;
                mode_next  = DRV_NONE;
                drive_next = 1'b0;
                path_next  = 1'b0;
                abs_next   = 1'b0;
                hp_next    = 1'b0;
                pos_next   = '0;
                after_next = 1'b1;
                slash_next = 1'b0;
                dir_next   = '0;
                kind_next  = K_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg   <= 1'b0;
            mode_reg  <= DRV_NONE;
            drive_reg <= 1'b0;
            path_reg  <= 1'b0;
            abs_reg   <= 1'b0;
            hp_reg    <= 1'b0;
            pos_reg   <= '0;
            after_reg <= 1'b1;
            slash_reg <= 1'b0;
            dir_reg   <= '0;
            kind_reg  <= K_EMPTY;
        end
        else
        begin
            bad_reg   <= bad_next;
            mode_reg  <= mode_next;
            drive_reg <= drive_next;
            path_reg  <= path_next;
            abs_reg   <= abs_next;
            hp_reg    <= hp_next;
            pos_reg   <= pos_next;
            after_reg <= after_next;
            slash_reg <= slash_next;
            dir_reg   <= dir_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

>>> sv/pnc_out_stage.sv
// ============================================================================
// pnc_out_stage
// Result register. Holds one classification until the consumer takes it.
// ============================================================================
module pnc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pnc_pkg::pnc_res_t res_in,
    input  logic              res_stall,
    output logic              res_valid,
    output logic              room,
    output pnc_pkg::pnc_res_t res_out
);
    import pnc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    pnc_res_t data_reg;

    // Free when empty or being taken this cycle
    assign room       = !valid_reg || !res_stall;
    assign valid_next = load || (valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign res_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

>>> sv/pnc_checker.sv
// ============================================================================
// pnc_checker
// Port-level checks on the path name classifier, bound to the top level.
// ============================================================================
module pnc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        byte_valid,
    input logic                        byte_stall,
    input logic [pnc_pkg::CH_W-1:0]    ch,
    input logic                        res_valid,
    input logic                        res_stall,
    input logic                        invalid,
    input logic                        has_drive,
    input logic                        has_path,
    input logic                        absolute,
    input logic                        ends_slash,
    input logic                        hp_drive,
    input logic                        name_empty,
    input logic                        single_dot,
    input logic                        double_dot,
    input logic [pnc_pkg::DEPTH_W-1:0] depth
);

    // A stalled result holds until transferred
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(invalid) &&
        $stable(depth) && $stable(has_path) && $stable(name_empty))
        else $error("result changed while stalled");

    // An invalid mark carries no other information
    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && invalid |-> !has_drive && !has_path && !absolute &&
        !ends_slash && !hp_drive && !name_empty && !single_dot &&
        !double_dot && (depth == '0))
        else $error("invalid result with flags set");

    // The last component has at most one special kind
    a_kind_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0({name_empty, single_dot, double_dot}))
        else $error("conflicting last component kinds");

    // Flag implications: HP drive is a drive, root and trailing slash need a path
    a_flag_deps: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!hp_drive || has_drive) && (!absolute || has_path) &&
        (!ends_slash || (has_path && name_empty)) &&
        ((depth == '0) || has_path))
        else $error("inconsistent result flags");

endmodule

bind path_name_classifier pnc_checker u_pnc_checker (.*);
